[hdl/smbios_structure_walker_unit_defines.svh]
// ----------------------------------------------------------------------------
// smbios structure walker assertion macros
// concurrent check wrappers on clock, disabled while reset is high
// ----------------------------------------------------------------------------
`ifndef SMBIOS_STRUCTURE_WALKER_UNIT_DEFINES_SVH
`define SMBIOS_STRUCTURE_WALKER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// expression holds at every edge
`define SMBSW_ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define SMBSW_ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define SMBSW_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define SMBSW_ASSERT_ALWAYS(lbl, expr, msg)
`define SMBSW_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define SMBSW_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[hdl/smbsw_pkg.sv]
// ----------------------------------------------------------------------------
// smbsw_pkg
// shared types and constants of the smbios structure walker
// ----------------------------------------------------------------------------
package smbsw_pkg;

   localparam int unsigned HeaderBytes     = 4;
   localparam int unsigned TerminatorBytes = 2;

   // register index, taken from paddr[2]
   typedef enum logic [0:0] {
      REG_TABLE_LENGTH    = 1'b0,
      REG_STRUCTURE_LIMIT = 1'b1
   } smbsw_reg_type;

   typedef struct packed {
      logic [15:0] byte_position;
      logic [15:0] structure_start;
      logic [15:0] structures_seen;
      logic        walk_finished;
      logic [7:0]  captured_type;
      logic [7:0]  captured_length;
      logic [15:0] captured_handle;
      logic        previous_was_zero;
   } smbsw_state_type;

   typedef struct packed {
      logic [15:0] table_length;
      logic [15:0] structure_limit;
   } smbsw_cfg_type;

   typedef struct packed {
      logic [7:0]  structure_type;
      logic [7:0]  structure_length;
      logic [15:0] structure_handle;
      logic [15:0] structure_offset;
      logic        status;
      logic        last;
   } smbsw_result_type;

endpackage

[hdl/smbsw_step.sv]
// ----------------------------------------------------------------------------
// smbsw_step
// per-byte walk logic: next walk state and the optional result of one byte
// ----------------------------------------------------------------------------
module smbsw_step import smbsw_pkg::*; (
   input  smbsw_state_type  cur_state,
   input  smbsw_cfg_type    cfg,
   input  logic [7:0]       data_byte,
   output smbsw_state_type  next_state,
   output logic             emit,
   output smbsw_result_type result
);

   logic [15:0] rel;
   logic [7:0]  flen;
   logic [16:0] scan_from;
   logic [15:0] pos_m1;
   logic [16:0] pos_p1;
   logic [17:0] next_end;
   logic [16:0] cur_end;
   logic [16:0] seen_p1;
   logic        start_ok;
   logic        more;
   logic        found;
   logic        trunc;
   logic        is_zero;

   always_comb begin
      rel       = cur_state.byte_position - cur_state.structure_start;
      flen      = (cur_state.captured_length < 8'(HeaderBytes)) ?
                  8'(HeaderBytes) : cur_state.captured_length;
      scan_from = {1'b0, cur_state.structure_start} + {9'b0, flen};
      pos_m1    = cur_state.byte_position - 16'd1;
      pos_p1    = {1'b0, cur_state.byte_position} + 17'd1;
      cur_end   = {1'b0, cur_state.structure_start} + 17'(HeaderBytes);
      seen_p1   = {1'b0, cur_state.structures_seen} + 17'd1;
      // next structure starts right after the second terminator byte
      next_end  = {2'b0, cur_state.byte_position} + 18'(TerminatorBytes - 1)
                  + 18'(HeaderBytes);
      is_zero   = (data_byte == 8'd0);
      start_ok  = (cur_state.structures_seen < cfg.structure_limit) &&
                  (cur_end <= {1'b0, cfg.table_length});
      more      = (seen_p1 < {1'b0, cfg.structure_limit}) &&
                  (next_end <= {2'b0, cfg.table_length});

      next_state = cur_state;
      emit       = 1'b0;
      found      = 1'b0;
      trunc      = 1'b0;

      if (!cur_state.walk_finished) begin
         if (rel == 16'd0 && !start_ok) begin
            next_state.walk_finished = 1'b1;
         end else begin
            priority if (rel == 16'd0) begin
               next_state.captured_type = data_byte;
            end else if (rel == 16'd1) begin
               next_state.captured_length = data_byte;
            end else if (rel == 16'd2) begin
               next_state.captured_handle = {8'd0, data_byte};
            end else if (rel == 16'd3) begin
               next_state.captured_handle = {data_byte, cur_state.captured_handle[7:0]};
            end else begin
               found = ({1'b0, pos_m1} >= scan_from) && cur_state.previous_was_zero &&
                       is_zero && (cur_state.byte_position < cfg.table_length);
            end
            trunc = !found && (pos_p1 >= {1'b0, cfg.table_length});

            if (found) begin
               emit = 1'b1;
               next_state.structures_seen = seen_p1[15:0];
               next_state.structure_start = pos_p1[15:0];
               next_state.walk_finished   = !more;
            end else if (trunc) begin
               emit = 1'b1;
               next_state.walk_finished = 1'b1;
            end
            next_state.previous_was_zero = is_zero;
            next_state.byte_position     = pos_p1[15:0];
         end
      end

      // header fields include the capture made by this byte
      result.structure_type   = next_state.captured_type;
      result.structure_length = next_state.captured_length;
      result.structure_handle = next_state.captured_handle;
      result.structure_offset = cur_state.structure_start;
      result.status           = trunc;
      result.last             = trunc || !more;
   end

endmodule

[hdl/smbios_structure_walker_unit.sv]
// ----------------------------------------------------------------------------
// smbios_structure_walker_unit
// walks an smbios structure table byte by byte and reports each structure
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake               payload
//   req       in         req_valid / req_ready   data_byte, one table byte
//   rsp       out        rsp_valid / rsp_ready   header fields, offset, status, last
//   csr       in/out     apb, pready tied high   table_length @0, structure_limit @4
//
//   one byte per cycle sustained while no result is held; a byte waits in the input
//   register until the step takes it, and its result, if any, is registered for rsp
//   rate is set by the combinational walk step between input and result register
//   a held result stalls the step only while rsp_ready is low
//   reset is synchronous, active high; a csr write also re-arms the walk
//
module smbios_structure_walker_unit
   import smbsw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // table byte beats
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   // structure result beats
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_structure_type,
   output logic [7:0]  rsp_structure_length,
   output logic [15:0] rsp_structure_handle,
   output logic [15:0] rsp_structure_offset,
   output logic        rsp_status,
   output logic        rsp_last,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

`include "smbios_structure_walker_unit_defines.svh"

   // input register
   logic             in_valid_ff;
   logic [7:0]       in_byte_ff;
   // walk state and configuration
   smbsw_state_type  state_ff;
   smbsw_state_type  state_in;
   smbsw_cfg_type    cfg_ff;
   // result register
   logic             out_valid_ff;
   smbsw_result_type out_ff;
   smbsw_result_type step_result;
   logic             step_emit;
   // control
   logic             step_fire;
   logic             cfg_we;
   smbsw_reg_type    cfg_sel;

   assign pready  = 1'b1;
   assign cfg_we  = psel && penable && pwrite && pready;
   assign cfg_sel = smbsw_reg_type'(paddr[2]);

   // register read back
   always_comb begin
      unique case (cfg_sel)
         REG_TABLE_LENGTH:    prdata = {16'd0, cfg_ff.table_length};
         REG_STRUCTURE_LIMIT: prdata = {16'd0, cfg_ff.structure_limit};
         default:             prdata = 32'd0;
      endcase
   end

   // step runs when its result, if any, has somewhere to go
   assign step_fire = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step_fire;

   smbsw_step u_step (
      .cur_state  (state_ff),
      .cfg        (cfg_ff),
      .data_byte  (in_byte_ff),
      .next_state (state_in),
      .emit       (step_emit),
      .result     (step_result)
   );

   // input beat capture
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
      end
   end

   // configuration and walk state; any register write re-arms the walk
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff   <= '0;
         state_ff <= '0;
      end else if (cfg_we) begin
         unique case (cfg_sel)
            REG_TABLE_LENGTH:    cfg_ff.table_length    <= pwdata[15:0];
            REG_STRUCTURE_LIMIT: cfg_ff.structure_limit <= pwdata[15:0];
            default:             cfg_ff                 <= cfg_ff;
         endcase
         state_ff <= '0;
      end else if (step_fire) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step_fire && step_emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
      if (step_fire && step_emit) begin
         out_ff <= step_result;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_structure_type   = out_ff.structure_type;
   assign rsp_structure_length = out_ff.structure_length;
   assign rsp_structure_handle = out_ff.structure_handle;
   assign rsp_structure_offset = out_ff.structure_offset;
   assign rsp_status           = out_ff.status;
   assign rsp_last             = out_ff.last;

   // a finished walk gives no more results
   `SMBSW_ASSERT_IMPLIES(a_no_result_after_end, state_ff.walk_finished, !step_emit, "result after walk end")
   // a result marked last closes the walk
   `SMBSW_ASSERT_NEXT(a_last_closes_walk, step_fire && step_emit && step_result.last && !cfg_we, state_ff.walk_finished, "last result left walk open")
   // a truncated structure is always the final one
   `SMBSW_ASSERT_IMPLIES(a_trunc_is_last, out_valid_ff && out_ff.status, out_ff.last, "truncated result not last")
   // never more structures than the configured structure limit
   `SMBSW_ASSERT_ALWAYS(a_seen_in_limit, state_ff.structures_seen <= cfg_ff.structure_limit, "structure count above limit")

endmodule
